// ===== sv/qpa_pkg.sv =====
// Shared widths, words and types for the quadrature positioning axis.
package qpa_pkg;

   localparam int POS_BITS   = 32;
   localparam int MOVE_BITS  = 24;
   localparam int CNT_BITS   = 24;
   localparam int DUTY_BITS  = 8;
   localparam int BRAKE_BITS = 16;
   localparam int CMD_BITS   = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;

   // command codes on the input word
   localparam logic [CMD_BITS-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_START = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_HOME  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_NONE  = 2'd3;

   // register indexes; byte address is four times the index
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_ZONE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DONE      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_FAST_DUTY = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SLOW_DUTY = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_BRAKE     = 3'd4;

   typedef struct packed {
      logic [CMD_BITS-1:0]         cmd;
      logic                        enc_a;
      logic                        enc_b;
      logic signed [MOVE_BITS-1:0] move_counts;
   } item_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]   slow_zone_counts;
      logic [CNT_BITS-1:0]   done_counts;
      logic [DUTY_BITS-1:0]  fast_duty;
      logic [DUTY_BITS-1:0]  slow_duty;
      logic [BRAKE_BITS-1:0] brake_ticks;
   } cfg_type;

   typedef struct packed {
      logic                       drive_in1;
      logic                       drive_in2;
      logic [DUTY_BITS-1:0]       duty;
      logic                       moving;
      logic                       braking;
      logic signed [POS_BITS-1:0] position;
      logic                       rejected;
   } result_type;

endpackage

// ===== sv/quadrature_positioning_axis.sv =====
// Top level of the quadrature positioning axis: input register, axis update, result queue.
// Path: a word accepted into the input register goes through the axis update, which writes
// its result into the result queue; it shows on rsp from there and leaves when rsp_stall is low.
// Throughput: one word per cycle while the result queue has room, set by the axis update.
// Reset (synchronous): position, move and brake state cleared, drive coasting, registers
// back to defaults, no result pending.
module quadrature_positioning_axis (
   input  logic                                  clock,
   input  logic                                  reset,
   // input words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [qpa_pkg::CMD_BITS-1:0]          req_cmd,
   input  logic                                  req_enc_a,
   input  logic                                  req_enc_b,
   input  logic signed [qpa_pkg::MOVE_BITS-1:0]  req_move_counts,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_drive_in1,
   output logic                                  rsp_drive_in2,
   output logic [qpa_pkg::DUTY_BITS-1:0]         rsp_duty,
   output logic                                  rsp_moving,
   output logic                                  rsp_braking,
   output logic signed [qpa_pkg::POS_BITS-1:0]   rsp_position,
   output logic                                  rsp_rejected,
   // configuration
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [qpa_pkg::CSR_ADDR_BITS-1:0]     csr_paddr,
   input  logic [qpa_pkg::CSR_DATA_BITS-1:0]     csr_pwdata,
   output logic [qpa_pkg::CSR_DATA_BITS-1:0]     csr_prdata,
   output logic                                  csr_pready
);
   import qpa_pkg::*;

   // Flow: req -> item_ff -> qpa_core (one pass, updates axis state) -> qpa_outq -> rsp.
   // The queue holds two words, so the input side keeps moving while one result
   // waits on a stalled output; the input only stalls when both slots are taken
   // and nothing leaves this cycle.

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       item_valid_ff, item_valid_in;
   logic       accept;
   logic       advance;
   logic       q_space;
   result_type result;
   result_type head_word;

   qpa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // input register
   assign advance   = item_valid_ff && q_space;
   assign req_stall = item_valid_ff && !q_space;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in             = item_ff;
      item_valid_in       = item_valid_ff && !advance;
      if (accept) begin
         item_in.cmd         = req_cmd;
         item_in.enc_a       = req_enc_a;
         item_in.enc_b       = req_enc_b;
         item_in.move_counts = req_move_counts;
         item_valid_in       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   // axis update: state moves only when the word goes on into the queue
   qpa_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   qpa_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (advance),
      .push_word (result),
      .space     (q_space),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .head_word (head_word)
   );

   assign rsp_drive_in1 = head_word.drive_in1;
   assign rsp_drive_in2 = head_word.drive_in2;
   assign rsp_duty      = head_word.duty;
   assign rsp_moving    = head_word.moving;
   assign rsp_braking   = head_word.braking;
   assign rsp_position  = head_word.position;
   assign rsp_rejected  = head_word.rejected;

endmodule

// ===== sv/qpa_csr.sv =====
// Configuration register file behind the APB-style port.
module qpa_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [qpa_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [qpa_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [qpa_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                              csr_pready,
   output qpa_pkg::cfg_type                  cfg
);
   import qpa_pkg::*;

   localparam int IDX_BITS = CSR_IDX_BITS;

   localparam logic [CNT_BITS-1:0]   RST_SLOW_ZONE = 24'd76642;
   localparam logic [CNT_BITS-1:0]   RST_DONE      = 24'd1277;
   localparam logic [DUTY_BITS-1:0]  RST_FAST_DUTY = 8'd255;
   localparam logic [DUTY_BITS-1:0]  RST_SLOW_DUTY = 8'd120;
   localparam logic [BRAKE_BITS-1:0] RST_BRAKE     = 16'd250;

   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                wr_en;
   logic [IDX_BITS-1:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_BITS-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_SLOW_ZONE: cfg_in.slow_zone_counts = csr_pwdata[CNT_BITS-1:0];
            REG_DONE:      cfg_in.done_counts      = csr_pwdata[CNT_BITS-1:0];
            REG_FAST_DUTY: cfg_in.fast_duty        = csr_pwdata[DUTY_BITS-1:0];
            REG_SLOW_DUTY: cfg_in.slow_duty        = csr_pwdata[DUTY_BITS-1:0];
            REG_BRAKE:     cfg_in.brake_ticks      = csr_pwdata[BRAKE_BITS-1:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_SLOW_ZONE: csr_prdata = CSR_DATA_BITS'(cfg_ff.slow_zone_counts);
         REG_DONE:      csr_prdata = CSR_DATA_BITS'(cfg_ff.done_counts);
         REG_FAST_DUTY: csr_prdata = CSR_DATA_BITS'(cfg_ff.fast_duty);
         REG_SLOW_DUTY: csr_prdata = CSR_DATA_BITS'(cfg_ff.slow_duty);
         REG_BRAKE:     csr_prdata = CSR_DATA_BITS'(cfg_ff.brake_ticks);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.slow_zone_counts <= RST_SLOW_ZONE;
         cfg_ff.done_counts      <= RST_DONE;
         cfg_ff.fast_duty        <= RST_FAST_DUTY;
         cfg_ff.slow_duty        <= RST_SLOW_DUTY;
         cfg_ff.brake_ticks      <= RST_BRAKE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== sv/qpa_core.sv =====
// Axis state and the per-word position, move and drive update.
module qpa_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  qpa_pkg::item_type   item,
   input  qpa_pkg::cfg_type    cfg,
   output qpa_pkg::result_type result
);
   import qpa_pkg::*;

   // two extra bits hold the exact signed distance
   localparam int DIFF_BITS = POS_BITS + 2;
   localparam logic [DUTY_BITS-1:0] BRAKE_DUTY = '1;

   typedef struct packed {
      logic                 in1;
      logic                 in2;
      logic [DUTY_BITS-1:0] duty;
   } drive_type;

   localparam drive_type COAST = '{in1: 1'b0, in2: 1'b0, duty: '0};
   localparam drive_type BRAKE = '{in1: 1'b1, in2: 1'b1, duty: BRAKE_DUTY};

   function automatic drive_type drive_run(input logic fwd, input logic [DUTY_BITS-1:0] d);
      drive_type r;
      if (d == '0) begin
         r = COAST;
      end else begin
         r.in1  = fwd;
         r.in2  = !fwd;
         r.duty = d;
      end
      return r;
   endfunction

   logic [POS_BITS-1:0]   pos_ff, pos_in, pos_step;
   logic                  last_a_ff, last_a_in;
   logic [POS_BITS-1:0]   origin_ff, origin_in;
   logic [MOVE_BITS-1:0]  target_ff, target_in;
   logic                  run_ff, run_in;
   logic [BRAKE_BITS-1:0] brake_left_ff, brake_left_in;
   drive_type             drive_ff, drive_in;
   logic                  rejected;

   logic [POS_BITS-1:0]         moved;
   logic signed [DIFF_BITS-1:0] diff;
   logic [DIFF_BITS-1:0]        remain;
   logic                        fwd;
   logic                        reached;
   logic                        slow_hit;
   logic                        done_hit;

   // encoder step: A edge, direction from B against A
   always_comb begin
      pos_step = pos_ff;
      if (item.enc_a != last_a_ff) begin
         if (item.enc_b != item.enc_a) pos_step = pos_ff + POS_BITS'(1);
         else                          pos_step = pos_ff - POS_BITS'(1);
      end
   end

   // signed distance to go, on the freshly stepped position
   assign moved    = pos_step - origin_ff;
   assign diff     = DIFF_BITS'(signed'(target_ff)) - DIFF_BITS'(signed'(moved));
   assign remain   = diff[DIFF_BITS-1] ? unsigned'(-diff) : unsigned'(diff);
   assign fwd      = !target_ff[MOVE_BITS-1];
   assign reached  = fwd ? (diff[DIFF_BITS-1] || diff == '0) : !diff[DIFF_BITS-1];
   assign slow_hit = remain <= DIFF_BITS'(cfg.slow_zone_counts);
   assign done_hit = remain <= DIFF_BITS'(cfg.done_counts);

   always_comb begin
      pos_in        = pos_ff;
      last_a_in     = last_a_ff;
      origin_in     = origin_ff;
      target_in     = target_ff;
      run_in        = run_ff;
      brake_left_in = brake_left_ff;
      drive_in      = drive_ff;
      rejected      = 1'b0;
      case (item.cmd)
         CMD_TICK: begin
            pos_in    = pos_step;
            last_a_in = item.enc_a;
            if (brake_left_ff != '0) begin
               brake_left_in = brake_left_ff - BRAKE_BITS'(1);
               if (brake_left_ff == BRAKE_BITS'(1)) drive_in = COAST;
            end
            if (run_ff) begin
               if (slow_hit) drive_in = drive_run(fwd, cfg.slow_duty);
               if (reached || done_hit) begin
                  run_in        = 1'b0;
                  brake_left_in = cfg.brake_ticks;
                  drive_in      = (cfg.brake_ticks != '0) ? BRAKE : COAST;
               end
            end
         end
         CMD_START: begin
            if (item.move_counts == '0 || brake_left_ff != '0) begin
               rejected = 1'b1;
            end else begin
               origin_in = pos_ff;
               target_in = unsigned'(item.move_counts);
               run_in    = 1'b1;
               drive_in  = drive_run(!item.move_counts[MOVE_BITS-1], cfg.fast_duty);
            end
         end
         CMD_HOME: begin
            pos_in = '0;
         end
         CMD_NONE: begin
            rejected = 1'b0;
         end
         default: begin
            rejected = 1'b0;
         end
      endcase
   end

   assign result.drive_in1 = drive_in.in1;
   assign result.drive_in2 = drive_in.in2;
   assign result.duty      = drive_in.duty;
   assign result.moving    = run_in;
   assign result.braking   = brake_left_in != '0;
   assign result.position  = signed'(pos_in);
   assign result.rejected  = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         last_a_ff     <= 1'b0;
         origin_ff     <= '0;
         target_ff     <= '0;
         run_ff        <= 1'b0;
         brake_left_ff <= '0;
         drive_ff      <= COAST;
      end else if (step_en) begin
         pos_ff        <= pos_in;
         last_a_ff     <= last_a_in;
         origin_ff     <= origin_in;
         target_ff     <= target_in;
         run_ff        <= run_in;
         brake_left_ff <= brake_left_in;
         drive_ff      <= drive_in;
      end
   end

endmodule

// ===== sv/qpa_outq.sv =====
// Two-word result register with skid slot on the result side.
module qpa_outq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qpa_pkg::result_type push_word,
   output logic                space,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output qpa_pkg::result_type head_word
);
   import qpa_pkg::*;

   logic [1:0] count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;
   logic       pop;

   assign rsp_valid = count_ff != 2'd0;
   assign pop       = rsp_valid && !rsp_stall;
   assign space     = (count_ff != 2'd2) || pop;
   assign head_word = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff;
      if (pop) begin
         slot0_in = slot1_ff;
         count_in = count_ff - 2'd1;
      end
      if (push) begin
         // after any pop, the new word lands in the first free slot
         if (count_in == 2'd0) slot0_in = push_word;
         else                  slot1_in = push_word;
         count_in = count_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

// ===== sv/qpa_checker.sv =====
// Port-level checks for the quadrature positioning axis, bound to the top level.
module qpa_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_drive_in1,
   input logic                                  rsp_drive_in2,
   input logic [qpa_pkg::DUTY_BITS-1:0]         rsp_duty,
   input logic                                  rsp_moving,
   input logic                                  rsp_braking,
   input logic signed [qpa_pkg::POS_BITS-1:0]   rsp_position,
   input logic                                  rsp_rejected
);
   import qpa_pkg::*;

   // short brake shown on the bridge exactly while the brake is held, at full duty
   a_brake_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_drive_in1 && rsp_drive_in2) == rsp_braking)
                    && (!rsp_braking || rsp_duty == '1))
      else $error("brake drive and braking flag disagree");

   // a move and the brake never overlap
   a_move_or_brake: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_moving && rsp_braking))
      else $error("moving while braking");

   // idle axis coasts
   a_idle_coast: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_moving && !rsp_braking |->
         !rsp_drive_in1 && !rsp_drive_in2 && rsp_duty == '0)
      else $error("idle axis not coasting");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_position)
                                && $stable(rsp_duty) && $stable(rsp_rejected))
      else $error("stalled result word changed");

   // nothing pending straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result pending after reset");

endmodule

bind quadrature_positioning_axis qpa_checker u_qpa_checker (.*);
